@@ rtl/hmne_pkg.sv @@
// shared types, constants and tables of the height map normal engine
`timescale 1ns / 1ps
`default_nettype none

package hmne_pkg;

   localparam int DEF_MAX_WIDTH_LOG2  = 6;
   localparam int DEF_MAX_HEIGHT_LOG2 = 6;

   localparam int HEIGHT_W = 32;
   localparam int DIFF_W   = 33;
   localparam int VEC_W    = 36;
   localparam int UNIT_W   = 18;
   localparam int SUM_W    = 21;
   localparam int NB_COUNT = 8;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic       OP_WRITE   = 1'b0;
   localparam logic       OP_COMPUTE = 1'b1;

   localparam logic [1:0] CSR_WIDTH_LOG2  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT_LOG2 = 2'd1;
   localparam logic [1:0] CSR_PIXEL_BYTES = 2'd2;

   typedef logic signed [DIFF_W-1:0]   diff_type;
   typedef logic [NB_COUNT*DIFF_W-1:0] diff_set_type;
   typedef logic signed [VEC_W-1:0]    vec_type;
   typedef logic signed [UNIT_W-1:0]   unit_type;

   localparam unit_type UNIT_ONE = 18'sd65536;

   typedef struct packed {
      logic [2:0] width_log2;
      logic [2:0] height_log2;
      logic [2:0] pixel_bytes;
   } cfg_type;

   // neighbour order N NE E SE S SW W NW
   localparam logic signed [1:0] NB_DROW [0:7] =
      '{-2'sd1, -2'sd1, 2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1};
   localparam logic signed [1:0] NB_DCOL [0:7] =
      '{2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1};
   localparam logic signed [1:0] NB_VY [0:7] =
      '{2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1};

endpackage

`default_nettype wire

@@ rtl/height_map_normal_engine.sv @@
// top level of the height map normal engine
//
// Holds a toroidal height image in an on-chip memory with one write and one
// read port and no reset; entries must be written before they are read. A
// write beat is taken whenever the front end is idle. A compute beat occupies
// the front end for nine memory reads, one per cycle, and then passes its
// eight height differences through a two-entry queue to the back end, which
// makes nine passes per normal through one shared normaliser, each with a
// one-bit-per-cycle scaling shift, three squarings, a 31-step square root
// and three 17-step divisions. A pass whose vector is zero goes straight to
// done and skips these steps, so flat ground is much quicker. Writes keep
// flowing while the back end works, until a compute beat meets a full queue.
`timescale 1ns / 1ps
`default_nettype none

module height_map_normal_engine import hmne_pkg::*; #(
   parameter int MAX_WIDTH_LOG2  = DEF_MAX_WIDTH_LOG2,
   parameter int MAX_HEIGHT_LOG2 = DEF_MAX_HEIGHT_LOG2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_opcode,
   input  wire logic [5:0]          req_row,
   input  wire logic [5:0]          req_col,
   input  wire logic [HEIGHT_W-1:0] req_height_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_normal_x,
   output logic [7:0]               rsp_normal_y,
   output logic [7:0]               rsp_normal_z,
   input  wire logic                csr_write,
   input  wire logic [1:0]          csr_index,
   input  wire logic [2:0]          csr_data
);

   cfg_type      cfg_ff, cfg_in;
   logic         push, full, not_empty, pop;
   diff_set_type push_data, pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_WIDTH_LOG2:  cfg_in.width_log2  = csr_data;
            CSR_HEIGHT_LOG2: cfg_in.height_log2 = csr_data;
            CSR_PIXEL_BYTES: cfg_in.pixel_bytes = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_log2  <= 3'd6;
         cfg_ff.height_log2 <= 3'd6;
         cfg_ff.pixel_bytes <= 3'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hmne_front #(
      .MAX_WIDTH_LOG2  (MAX_WIDTH_LOG2),
      .MAX_HEIGHT_LOG2 (MAX_HEIGHT_LOG2)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_height_value (req_height_value),
      .push             (push),
      .push_data        (push_data),
      .queue_full       (full)
   );

   hmne_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   hmne_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (not_empty),
      .q_data       (pop_data),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_normal_x (rsp_normal_x),
      .rsp_normal_y (rsp_normal_y),
      .rsp_normal_z (rsp_normal_z)
   );

endmodule

`default_nettype wire

@@ rtl/hmne_front.sv @@
// front end: height memory, item intake and neighbourhood fetch
`timescale 1ns / 1ps
`default_nettype none

module hmne_front import hmne_pkg::*; #(
   parameter int MAX_WIDTH_LOG2  = DEF_MAX_WIDTH_LOG2,
   parameter int MAX_HEIGHT_LOG2 = DEF_MAX_HEIGHT_LOG2
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cfg_type             cfg,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_opcode,
   input  wire logic [5:0]          req_row,
   input  wire logic [5:0]          req_col,
   input  wire logic [HEIGHT_W-1:0] req_height_value,
   output logic                     push,
   output diff_set_type             push_data,
   input  wire logic                queue_full
);

   localparam int ADDR_W = MAX_WIDTH_LOG2 + MAX_HEIGHT_LOG2;
   localparam int DEPTH  = 1 << ADDR_W;

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_READ = 2'd1;
   localparam logic [1:0] F_LAST = 2'd2;
   localparam logic [1:0] F_PUSH = 2'd3;

   localparam logic [3:0] LAST_READ = 4'd8;

   logic [HEIGHT_W-1:0]        height_mem_ff [DEPTH];
   logic [HEIGHT_W-1:0]        rd_data_ff;
   logic [HEIGHT_W-1:0]        h_ff [9];
   logic [1:0]                 st_ff, st_in;
   logic [3:0]                 cnt_ff, cnt_in;
   logic                       cap_vld_ff, cap_vld_in;
   logic [3:0]                 cap_idx_ff;
   logic [MAX_HEIGHT_LOG2-1:0] r_ff;
   logic [MAX_WIDTH_LOG2-1:0]  c_ff;

   logic [MAX_HEIGHT_LOG2-1:0] hmask, r_wrap, nr;
   logic [MAX_WIDTH_LOG2-1:0]  wmask, c_wrap, nc;
   logic [HEIGHT_W-1:0]        bmask;
   logic [ADDR_W-1:0]          rd_addr, wr_addr;
   logic                       accept, wr_en;
   logic [2:0]                 nb;
   logic signed [1:0]          drow, dcol;

   // effective sizes and sample mask
   always_comb begin
      int ew;
      int eh;
      int eb;
      ew = int'(cfg.width_log2);
      eh = int'(cfg.height_log2);
      eb = int'(cfg.pixel_bytes);
      if (ew < 1) ew = 1;
      if (ew > MAX_WIDTH_LOG2) ew = MAX_WIDTH_LOG2;
      if (eh < 1) eh = 1;
      if (eh > MAX_HEIGHT_LOG2) eh = MAX_HEIGHT_LOG2;
      if (eb < 1) eb = 1;
      if (eb > 4) eb = 4;
      for (int i = 0; i < MAX_WIDTH_LOG2; i++) wmask[i] = (i < ew);
      for (int i = 0; i < MAX_HEIGHT_LOG2; i++) hmask[i] = (i < eh);
      for (int i = 0; i < HEIGHT_W; i++) bmask[i] = (i < 8 * eb);
   end

   assign req_ready = (st_ff == F_IDLE);
   assign accept    = req_valid && req_ready;
   assign wr_en     = accept && (req_opcode == OP_WRITE);
   assign r_wrap    = MAX_HEIGHT_LOG2'(req_row) & hmask;
   assign c_wrap    = MAX_WIDTH_LOG2'(req_col) & wmask;
   assign wr_addr   = {r_wrap, c_wrap};

   // centre first, then the eight neighbours
   assign nb      = 3'(cnt_ff - 4'd1);
   assign drow    = (cnt_ff == 4'd0) ? 2'sd0 : NB_DROW[nb];
   assign dcol    = (cnt_ff == 4'd0) ? 2'sd0 : NB_DCOL[nb];
   assign nr      = (r_ff + MAX_HEIGHT_LOG2'(drow)) & hmask;
   assign nc      = (c_ff + MAX_WIDTH_LOG2'(dcol)) & wmask;
   assign rd_addr = {nr, nc};

   always_ff @(posedge clock) begin
      if (wr_en) height_mem_ff[wr_addr] <= req_height_value & bmask;
      rd_data_ff <= height_mem_ff[rd_addr];
   end

   always_comb begin
      st_in      = st_ff;
      cnt_in     = cnt_ff;
      cap_vld_in = 1'b0;
      case (st_ff)
         F_IDLE: begin
            if (accept && (req_opcode == OP_COMPUTE)) begin
               st_in  = F_READ;
               cnt_in = 4'd0;
            end
         end
         F_READ: begin
            cap_vld_in = 1'b1;
            cnt_in     = cnt_ff + 4'd1;
            if (cnt_ff == LAST_READ) st_in = F_LAST;
         end
         F_LAST: st_in = F_PUSH;
         F_PUSH: begin
            if (!queue_full) st_in = F_IDLE;
         end
         default: st_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff      <= F_IDLE;
         cnt_ff     <= 4'd0;
         cap_vld_ff <= 1'b0;
      end else begin
         st_ff      <= st_in;
         cnt_ff     <= cnt_in;
         cap_vld_ff <= cap_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         r_ff <= r_wrap;
         c_ff <= c_wrap;
      end
      cap_idx_ff <= cnt_ff;
      if (cap_vld_ff) h_ff[cap_idx_ff] <= rd_data_ff & bmask;
   end

   assign push = (st_ff == F_PUSH) && !queue_full;

   always_comb begin
      for (int k = 0; k < NB_COUNT; k++) begin
         push_data[k*DIFF_W +: DIFF_W] = {1'b0, h_ff[k+1]} - {1'b0, h_ff[0]};
      end
   end

endmodule

`default_nettype wire

@@ rtl/hmne_fifo.sv @@
// short queue of neighbourhood differences between front and back end
`timescale 1ns / 1ps
`default_nettype none

module hmne_fifo import hmne_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire diff_set_type push_data,
   output logic              full,
   input  wire logic         pop,
   output logic              not_empty,
   output diff_set_type      pop_data
);

   diff_set_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("beat pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("beat popped from empty queue");

endmodule

`default_nettype wire

@@ rtl/hmne_norm.sv @@
// shared vector normaliser: shift scaling, bit-serial square root and divider
`timescale 1ns / 1ps
`default_nettype none

module hmne_norm import hmne_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire vec_type vec_x,
   input  wire vec_type vec_y,
   input  wire vec_type vec_z,
   output logic         done,
   output unit_type     unit_x,
   output unit_type     unit_y,
   output unit_type     unit_z
);

   localparam logic [2:0] N_IDLE = 3'd0;
   localparam logic [2:0] N_RSH  = 3'd1;
   localparam logic [2:0] N_LSH  = 3'd2;
   localparam logic [2:0] N_SQ   = 3'd3;
   localparam logic [2:0] N_SQRT = 3'd4;
   localparam logic [2:0] N_DVLD = 3'd5;
   localparam logic [2:0] N_DIV  = 3'd6;
   localparam logic [2:0] N_DONE = 3'd7;

   localparam logic [VEC_W-1:0] MAG_HI = VEC_W'(64'd1 << 30);
   localparam logic [VEC_W-1:0] MAG_LO = VEC_W'(64'd1 << 29);

   logic [2:0]       st_ff, st_in;
   logic [VEC_W-1:0] m_ff [3];
   logic [VEC_W-1:0] mx_ff;
   logic             neg_ff [3];
   logic [1:0]       idx_ff;
   logic [61:0]      acc_ff, root_ff, bit_ff;
   logic [31:0]      rem_ff;
   logic [16:0]      dq_ff, q_ff;
   logic [4:0]       cnt_ff;
   unit_type         u_ff [3];

   vec_type          vin [3];
   logic [VEC_W-1:0] mag [3];
   logic [VEC_W-1:0] mx;
   logic [59:0]      sq;
   logic [61:0]      trial;
   logic [32:0]      rsh, lenv;
   logic [16:0]      q_fin;
   logic             start_ok;

   assign vin[0] = vec_x;
   assign vin[1] = vec_y;
   assign vin[2] = vec_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i] = vin[i][VEC_W-1] ? VEC_W'(-vin[i]) : VEC_W'(vin[i]);
      end
      mx = mag[0];
      if (mag[1] > mx) mx = mag[1];
      if (mag[2] > mx) mx = mag[2];
   end

   assign start_ok = start && ((st_ff == N_IDLE) || (st_ff == N_DONE));
   assign sq       = m_ff[idx_ff][29:0] * m_ff[idx_ff][29:0];
   assign trial    = root_ff + bit_ff;
   assign rsh      = {rem_ff, dq_ff[16]};
   assign lenv     = {1'b0, root_ff[31:0]};
   assign q_fin    = {q_ff[15:0], (rsh >= lenv)};

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         N_IDLE, N_DONE: begin
            if (start_ok) st_in = (mx == '0) ? N_DONE : N_RSH;
            else st_in = N_IDLE;
         end
         N_RSH: if (mx_ff < MAG_HI) st_in = N_LSH;
         N_LSH: if (mx_ff >= MAG_LO) st_in = N_SQ;
         N_SQ: if (idx_ff == 2'd2) st_in = N_SQRT;
         N_SQRT: if (bit_ff[0]) st_in = N_DVLD;
         N_DVLD: st_in = N_DIV;
         N_DIV: begin
            if (cnt_ff == 5'd16) st_in = (idx_ff == 2'd2) ? N_DONE : N_DVLD;
         end
         default: st_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= N_IDLE;
      else st_ff <= st_in;
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         N_IDLE, N_DONE: begin
            if (start_ok) begin
               for (int i = 0; i < 3; i++) begin
                  m_ff[i]   <= mag[i];
                  neg_ff[i] <= vin[i][VEC_W-1];
               end
               mx_ff <= mx;
               if (mx == '0) begin
                  u_ff[0] <= '0;
                  u_ff[1] <= '0;
                  u_ff[2] <= UNIT_ONE;
               end
            end
         end
         N_RSH: begin
            if (mx_ff >= MAG_HI) begin
               mx_ff <= mx_ff >> 1;
               for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 1;
            end else begin
               idx_ff <= 2'd0;
               acc_ff <= '0;
            end
         end
         N_LSH: begin
            if (mx_ff < MAG_LO) begin
               mx_ff <= mx_ff << 1;
               for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 1;
            end
            idx_ff <= 2'd0;
            acc_ff <= '0;
         end
         N_SQ: begin
            acc_ff <= acc_ff + 62'(sq);
            idx_ff <= idx_ff + 2'd1;
            root_ff <= '0;
            bit_ff  <= 62'(1) << 60;
         end
         N_SQRT: begin
            if (acc_ff >= trial) begin
               acc_ff  <= acc_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            idx_ff <= 2'd0;
         end
         N_DVLD: begin
            rem_ff <= 32'(m_ff[idx_ff][29:1]);
            dq_ff  <= {m_ff[idx_ff][0], 16'd0};
            q_ff   <= '0;
            cnt_ff <= '0;
         end
         N_DIV: begin
            if (rsh >= lenv) rem_ff <= 32'(rsh - lenv);
            else rem_ff <= rsh[31:0];
            q_ff   <= q_fin;
            dq_ff  <= dq_ff << 1;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               u_ff[idx_ff] <= neg_ff[idx_ff] ? -unit_type'({1'b0, q_fin})
                                              : unit_type'({1'b0, q_fin});
               idx_ff <= idx_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   assign done   = (st_ff == N_DONE);
   assign unit_x = u_ff[0];
   assign unit_y = u_ff[1];
   assign unit_z = u_ff[2];

endmodule

`default_nettype wire

@@ rtl/hmne_back.sv @@
// back end: cross products, accumulation, final normal and result register
`timescale 1ns / 1ps
`default_nettype none

module hmne_back import hmne_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_valid,
   input  wire diff_set_type q_data,
   output logic              pop,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [7:0]        rsp_normal_x,
   output logic [7:0]        rsp_normal_y,
   output logic [7:0]        rsp_normal_z
);

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_CROSS = 3'd1;
   localparam logic [2:0] B_WAIT  = 3'd2;
   localparam logic [2:0] B_FINAL = 3'd3;
   localparam logic [2:0] B_OUT   = 3'd4;

   function automatic logic signed [DIFF_W:0] sel_mul(logic signed [1:0] s,
                                                      diff_type z);
      logic signed [DIFF_W:0] r;
      r = '0;
      if (s == 2'sd1) r = (DIFF_W+1)'(z);
      else if (s == -2'sd1) r = -(DIFF_W+1)'(z);
      return r;
   endfunction

   function automatic logic [7:0] to_byte(unit_type u);
      logic [16:0] mag;
      logic [24:0] prod;
      logic [7:0]  t;
      mag  = u[UNIT_W-1] ? 17'(-u) : 17'(u);
      prod = 25'(mag) * 25'(8'd255);
      t    = prod[23:16];
      return u[UNIT_W-1] ? 8'(8'd0 - t) : t;
   endfunction

   logic [2:0]               st_ff, st_in;
   logic [2:0]               k_ff, k_in;
   diff_set_type             vz_ff;
   logic signed [SUM_W-1:0]  sum_ff [3];
   unit_type                 nrm_ff [3];
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_x_ff, rsp_y_ff, rsp_z_ff;

   logic [2:0]               ka, kb;
   diff_type                 za, zb;
   logic signed [1:0]        vxa, vxb, vya, vyb;
   vec_type                  cr [3];
   logic signed [SUM_W-1:0]  sum_nx [3];
   unit_type                 un [3];
   logic                     n_start, n_done;
   vec_type                  n_in [3];
   logic                     out_free;

   assign ka  = k_ff;
   assign kb  = k_ff - 3'd1;
   assign za  = $signed(vz_ff[ka*DIFF_W +: DIFF_W]);
   assign zb  = $signed(vz_ff[kb*DIFF_W +: DIFF_W]);
   assign vxa = NB_DCOL[ka];
   assign vxb = NB_DCOL[kb];
   assign vya = NB_VY[ka];
   assign vyb = NB_VY[kb];

   // pair k with k-1
   always_comb begin
      cr[0] = VEC_W'(sel_mul(vya, zb)) - VEC_W'(sel_mul(vyb, za));
      cr[1] = VEC_W'(sel_mul(vxb, za)) - VEC_W'(sel_mul(vxa, zb));
      cr[2] = VEC_W'(vxa * vyb) - VEC_W'(vya * vxb);
      for (int i = 0; i < 3; i++) sum_nx[i] = sum_ff[i] + SUM_W'(un[i]);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = (st_ff == B_CROSS) ? cr[i] : VEC_W'(sum_nx[i]);
      end
   end

   assign n_start  = (st_ff == B_CROSS) ||
                     ((st_ff == B_WAIT) && n_done && (k_ff == 3'd7));
   assign pop      = (st_ff == B_IDLE) && q_valid;
   assign out_free = !rsp_valid_ff || rsp_ready;

   hmne_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (n_start),
      .vec_x  (n_in[0]),
      .vec_y  (n_in[1]),
      .vec_z  (n_in[2]),
      .done   (n_done),
      .unit_x (un[0]),
      .unit_y (un[1]),
      .unit_z (un[2])
   );

   always_comb begin
      st_in        = st_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (st_ff)
         B_IDLE: begin
            if (q_valid) begin
               st_in = B_CROSS;
               k_in  = 3'd0;
            end
         end
         B_CROSS: st_in = B_WAIT;
         B_WAIT: begin
            if (n_done) begin
               if (k_ff == 3'd7) st_in = B_FINAL;
               else begin
                  st_in = B_CROSS;
                  k_in  = k_ff + 3'd1;
               end
            end
         end
         B_FINAL: if (n_done) st_in = B_OUT;
         B_OUT: begin
            if (out_free) begin
               st_in        = B_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= B_IDLE;
         k_ff         <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         vz_ff <= q_data;
         for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
      end
      if ((st_ff == B_WAIT) && n_done) begin
         for (int i = 0; i < 3; i++) sum_ff[i] <= sum_nx[i];
      end
      if ((st_ff == B_FINAL) && n_done) begin
         for (int i = 0; i < 3; i++) nrm_ff[i] <= un[i];
      end
      if ((st_ff == B_OUT) && out_free) begin
         rsp_x_ff <= to_byte(nrm_ff[0]);
         rsp_y_ff <= to_byte(nrm_ff[1]);
         rsp_z_ff <= to_byte(nrm_ff[2]);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_normal_x = rsp_x_ff;
   assign rsp_normal_y = rsp_y_ff;
   assign rsp_normal_z = rsp_z_ff;

endmodule

`default_nettype wire
